FILE: hw/rtl/srdf_pkg.sv
package srdf_pkg;

    // result codes
    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_CONFLICT  = 3'd2,
        ST_BIND_LIM  = 3'd3,
        ST_MISMATCH  = 3'd4,
        ST_BYTE_LIM  = 3'd5,
        ST_AUTH_FAIL = 3'd6,
        ST_IDX_RANGE = 3'd7
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_CHECK = 1'b1
    } t_state;

    // configuration register indexes
    localparam logic CFG_MAX_SEGMENTS = 1'b0;
    localparam logic CFG_MAX_BYTES    = 1'b1;

    localparam int unsigned EPOCH_W  = 64;
    localparam int unsigned OPIDX_W  = 64;
    localparam int unsigned SCNT_W   = 21;
    localparam int unsigned BYTES_W  = 36;
    localparam int unsigned SEGNO_W  = 20;
    localparam int unsigned PAY_W    = 25;
    localparam int unsigned DIGEST_W = 256;
    localparam int unsigned TALLY_W  = 11;

    localparam int unsigned S_TDATA_W = 488;
    localparam int unsigned M_TDATA_W = 56;

endpackage

FILE: hw/rtl/srdf_table.sv
module srdf_table #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  logic [srdf_pkg::DIGEST_W-1:0] i_wr_digest,
    output logic                          o_rd_valid,
    output logic [srdf_pkg::DIGEST_W-1:0] o_rd_digest,
    output logic                          o_clr_busy
);
    import srdf_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    logic                mem_valid  [DEPTH];
    logic [DIGEST_W-1:0] mem_digest [DEPTH];

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic          w_vwr_en;
    logic [AW-1:0] w_vwr_addr;
    logic          w_vwr_data;

    // clearing sweep over the valid bits after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_comb begin
        w_vwr_en   = r_clr_busy | i_wr_en;
        w_vwr_addr = r_clr_busy ? r_clr_addr : i_wr_addr;
        w_vwr_data = !r_clr_busy;
    end

    always_ff @(posedge i_clk) begin
        if (w_vwr_en) begin
            mem_valid[w_vwr_addr] <= w_vwr_data;
        end
        o_rd_valid <= mem_valid[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_digest[i_wr_addr] <= i_wr_digest;
        end
        o_rd_digest <= mem_digest[i_rd_addr];
    end

    assign o_clr_busy = r_clr_busy;

endmodule

FILE: hw/rtl/segment_replay_duplicate_filter.sv
// Duplicate segment filter for one transfer window.
// Slave stream: one transaction per authenticated segment descriptor; tuser carries
// auth_ok, tdata the descriptor fields and the 256-bit digest. Master stream: one
// transaction per descriptor with status, running counts and the complete flag.
// Configuration: i_cfg_we writes max_segments (index 0) or max_bytes (index 1); write
// only while no transaction is in flight.
// The result is registered. A new transaction is taken only after the last is checked:
// the idle state reads the per-segment table (valid bit and digest, one synchronous read
// port), the check state checks the entry and writes it back. The write completes before
// the next read, so no forwarding is needed.
// Reset: the window is unbound, tallies and limits return to their defaults, and the
// valid bits are swept clear with o_s_tready low.
// Receiver stall: a result waits in the output register; the next descriptor is still
// taken and its table entry read, and its check holds until the output register frees.
module segment_replay_duplicate_filter #(
    parameter int unsigned SEG_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata: epoch, operation_index, segment_count, total_bytes, segment_no,
    //        payload_bytes, digest_w0, digest_w1, digest_w2, digest_w3
    input  logic [srdf_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: auth_ok
    input  logic                           i_s_tuser,
    // master stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: status, accepted_segments, accepted_total, complete
    output logic [srdf_pkg::M_TDATA_W-1:0] o_m_tdata,
    // configuration
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_addr,
    input  logic [srdf_pkg::BYTES_W-1:0]   i_cfg_wdata
);
    import srdf_pkg::*;

    localparam int unsigned AW = $clog2(SEG_DEPTH);

    t_state r_state, n_state;

    logic [TALLY_W-1:0] r_max_seg;
    logic [BYTES_W-1:0] r_max_bytes;

    logic               r_bound;
    logic [EPOCH_W-1:0] r_b_epoch;
    logic [OPIDX_W-1:0] r_b_op;
    logic [SCNT_W-1:0]  r_b_count;
    logic [BYTES_W-1:0] r_b_total;
    logic [BYTES_W-1:0] r_byte_tally;
    logic [TALLY_W-1:0] r_seg_tally;

    logic                r_auth;
    logic [EPOCH_W-1:0]  r_epoch;
    logic [OPIDX_W-1:0]  r_op;
    logic [SCNT_W-1:0]   r_count;
    logic [BYTES_W-1:0]  r_total;
    logic [SEGNO_W-1:0]  r_segno;
    logic [PAY_W-1:0]    r_payload;
    logic [DIGEST_W-1:0] r_digest;

    logic                 r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;

    logic                s_accept;
    logic                w_do_check;
    logic                w_clr_busy;
    logic                w_rd_valid;
    logic [DIGEST_W-1:0] w_rd_digest;
    logic [AW-1:0]       w_rd_addr;

    logic               w_bind;
    logic               w_take;
    t_status            w_status;
    logic [BYTES_W-1:0] w_room;
    logic [TALLY_W-1:0] n_seg_tally;
    logic [BYTES_W-1:0] n_byte_tally;
    logic               n_bound;
    logic [SCNT_W-1:0]  n_b_count;
    logic [BYTES_W-1:0] n_b_total;
    logic               w_complete;

    srdf_table #(
        .DEPTH (SEG_DEPTH)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr   (w_rd_addr),
        .i_wr_en     (w_take),
        .i_wr_addr   (r_segno[AW-1:0]),
        .i_wr_digest (r_digest),
        .o_rd_valid  (w_rd_valid),
        .o_rd_digest (w_rd_digest),
        .o_clr_busy  (w_clr_busy)
    );

    assign w_rd_addr = s_accept ? i_s_tdata[185 +: AW] : r_segno[AW-1:0];

    // state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_do_check) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        w_do_check = 1'b0;
        unique case (r_state)
            S_IDLE:  o_s_tready = !w_clr_busy;
            S_CHECK: w_do_check = !r_m_tvalid || i_m_tready;
            default: ;
        endcase
    end

    assign s_accept = i_s_tvalid && o_s_tready;

    // classification
    always_comb begin
        w_bind   = 1'b0;
        w_take   = 1'b0;
        w_status = ST_ACCEPTED;
        w_room   = r_max_bytes - r_byte_tally;
        if (!r_auth) begin
            w_status = ST_AUTH_FAIL;
        end else if ({1'b0, r_segno} >= r_count) begin
            w_status = ST_IDX_RANGE;
        end else if (!r_bound && ((r_count > {10'b0, r_max_seg}) ||
                                  (r_total > r_max_bytes))) begin
            w_bind   = 1'b1;
            w_status = ST_BIND_LIM;
        end else begin
            w_bind = !r_bound;
            if (r_bound && ((r_epoch != r_b_epoch) || (r_op != r_b_op) ||
                            (r_count != r_b_count) || (r_total != r_b_total))) begin
                w_status = ST_MISMATCH;
            end else if ({1'b0, r_segno} >= 21'(SEG_DEPTH)) begin
                w_status = ST_IDX_RANGE;
            end else if (w_rd_valid) begin
                w_status = (w_rd_digest == r_digest) ? ST_DUPLICATE : ST_CONFLICT;
            end else if ((r_seg_tally >= r_max_seg) || (r_byte_tally > r_max_bytes) ||
                         ({11'b0, r_payload} > w_room)) begin
                w_status = ST_BYTE_LIM;
            end else begin
                w_take = 1'b1;
            end
        end
        w_bind = w_bind && w_do_check;
        w_take = w_take && w_do_check;
    end

    always_comb begin
        n_bound      = r_bound | w_bind;
        n_b_count    = w_bind ? r_count : r_b_count;
        n_b_total    = w_bind ? r_total : r_b_total;
        n_seg_tally  = w_take ? r_seg_tally + 1'b1 : r_seg_tally;
        n_byte_tally = w_take ? r_byte_tally + {11'b0, r_payload} : r_byte_tally;
        w_complete   = n_bound && ({10'b0, n_seg_tally} == n_b_count) &&
                       (n_byte_tally == n_b_total);
    end

    // control and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_max_seg    <= 11'd1024;
            r_max_bytes  <= 36'd16777216;
            r_bound      <= 1'b0;
            r_b_epoch    <= '0;
            r_b_op       <= '0;
            r_b_count    <= '0;
            r_b_total    <= '0;
            r_byte_tally <= '0;
            r_seg_tally  <= '0;
            r_m_tvalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_MAX_SEGMENTS: r_max_seg   <= i_cfg_wdata[TALLY_W-1:0];
                    CFG_MAX_BYTES:    r_max_bytes <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_bind) begin
                r_b_epoch <= r_epoch;
                r_b_op    <= r_op;
            end
            r_bound      <= n_bound;
            r_b_count    <= n_b_count;
            r_b_total    <= n_b_total;
            r_seg_tally  <= n_seg_tally;
            r_byte_tally <= n_byte_tally;
            if (w_do_check) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // input and output payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_auth    <= i_s_tuser;
            r_epoch   <= i_s_tdata[63:0];
            r_op      <= i_s_tdata[127:64];
            r_count   <= i_s_tdata[148:128];
            r_total   <= i_s_tdata[184:149];
            r_segno   <= i_s_tdata[204:185];
            r_payload <= i_s_tdata[229:205];
            r_digest  <= {i_s_tdata[293:230], i_s_tdata[357:294],
                          i_s_tdata[421:358], i_s_tdata[485:422]};
        end
        if (w_do_check) begin
            r_m_tdata <= {5'b0, w_complete, n_byte_tally, n_seg_tally, w_status};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule
